@@ hdl/sha1he_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 hash engine.
// No dependencies.
package sha1he_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned SCHED_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;

    localparam logic [7:0]  PAD_MARK   = 8'h80;
    localparam logic [4:0]  LEN_WORD   = 5'd14;
    localparam logic [4:0]  FULL_WORDS = 5'd16;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [2:0]  LAST_HWORD = 3'd4;
    localparam logic [2:0]  FIN_DONE   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD,
        S_ZERO,
        S_LEN_HI,
        S_LEN_LO,
        S_ROUND,
        S_FIN,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    typedef struct packed {
        logic        push;
        logic        expand;
        logic [31:0] word;
    } t_sched_ctl;

    typedef struct packed {
        logic       init;
        logic       step;
        logic       rot;
        logic [6:0] round;
    } t_round_ctl;

    function automatic logic [31:0] f_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hefcdab89;
            3'd2:    v = 32'h98badcfe;
            3'd3:    v = 32'h10325476;
            3'd4:    v = 32'hc3d2e1f0;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_round_k(input logic [6:0] t);
        logic [31:0] k;
        if (t < 7'd20) begin
            k = 32'h5a827999;
        end else if (t < 7'd40) begin
            k = 32'h6ed9eba1;
        end else if (t < 7'd60) begin
            k = 32'h8f1bbcdc;
        end else begin
            k = 32'hca62c1d6;
        end
        return k;
    endfunction

    function automatic logic [31:0] f_round_f(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z, input logic [6:0] t);
        logic [31:0] f;
        if (t < 7'd20) begin
            f = (x & y) ^ (~x & z);
        end else if (t < 7'd40) begin
            f = x ^ y ^ z;
        end else if (t < 7'd60) begin
            f = (x & y) ^ (x & z) ^ (y & z);
        end else begin
            f = x ^ y ^ z;
        end
        return f;
    endfunction

endpackage

@@ hdl/sha1he_if.sv @@
// Valid/ready channel interfaces for the SHA-1 hash engine.
// Depends on nothing.
interface sha1he_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] message_byte;
    modport source (output valid, output mode, output message_byte, input ready);
    modport sink (input valid, input mode, input message_byte, output ready);
endinterface

interface sha1he_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        overflow_error;
    modport source (output valid, output digest_word, output word_index, output last_word,
                    output overflow_error, input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  input overflow_error, output ready);
endinterface

@@ hdl/sha1he_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sha1he_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 5
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ hdl/sha1he_sched.sv @@
// 16-word message schedule line: loads block words, then expands in place.
// Depends on sha1he_pkg.
module sha1he_sched (
    input  logic                   i_clk,
    input  sha1he_pkg::t_sched_ctl i_ctl,
    output logic [31:0]            o_w0
);
    import sha1he_pkg::*;

    logic [31:0] r_w [SCHED_WORDS];
    logic [31:0] mix;
    logic [31:0] n_tail;

    always_comb begin
        mix    = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        n_tail = i_ctl.expand ? {mix[30:0], mix[31]} : i_ctl.word;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int i = 0; i < SCHED_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[SCHED_WORDS-1] <= n_tail;
        end
    end

    assign o_w0 = r_w[0];
endmodule

@@ hdl/sha1he_round.sv @@
// Working variables a..e, one compression round per cycle while step is set, and hash update rotation.
// Depends on sha1he_pkg.
module sha1he_round (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sha1he_pkg::t_round_ctl i_ctl,
    input  logic [31:0]            i_w,
    input  logic [31:0]            i_hword,
    output logic [31:0]            o_sum
);
    import sha1he_pkg::*;

    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] tmp;

    always_comb begin
        tmp   = {r_a[26:0], r_a[31:27]} + f_round_f(r_b, r_c, r_d, i_ctl.round)
              + r_e + f_round_k(i_ctl.round) + i_w;
        o_sum = i_hword + r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_a <= f_iv(3'd0);
            r_b <= f_iv(3'd1);
            r_c <= f_iv(3'd2);
            r_d <= f_iv(3'd3);
            r_e <= f_iv(3'd4);
        end else if (i_ctl.step) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end else if (i_ctl.rot) begin
            // after five turns a..e hold the updated hash words
            r_a <= r_b;
            r_b <= r_c;
            r_c <= r_d;
            r_d <= r_e;
            r_e <= o_sum;
        end
    end
endmodule

@@ hdl/sha1_hash_engine_top.sv @@
// SHA-1 hash engine top level: sequencer, hash word memory, output register.
// Depends on sha1he_pkg, sha1he_if, sha1he_ram, sha1he_sched, sha1he_round.
//
//  channel    dir  beat contents
//  i_in_ch    in   mode, message_byte
//  o_out_ch   out  digest_word, word_index, last_word, overflow_error
//
// The idle sequencer takes message bytes while ready; the 64th byte of a block
// then starts the compression rounds and a read-add-write pass on the hash
// word memory. A finish loads pad, zero and length words ahead of each of its
// one or two compressions, then emits each digest beat through the S_EMIT_RD
// and S_EMIT_WR states. A byte refused on overflow gets an error beat.
// Hash memory entries carry valid bits; no clearing pass after reset.
// Input is held off while busy or while a waiting result is not taken.
module sha1_hash_engine_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha1he_in_if.sink           i_in_ch,
    sha1he_out_if.source        o_out_ch
);
    import sha1he_pkg::*;

    t_state      r_state, n_state, r_ret, n_ret;
    logic [60:0] r_cnt, n_cnt;
    logic [23:0] r_word, n_word;
    logic [4:0]  r_wcnt, n_wcnt;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    logic [4:0]  r_hvalid, n_hvalid;
    logic        r_rd_iv;
    logic [2:0]  r_rd_idx;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_word, n_out_word;
    logic [2:0]  r_out_idx, n_out_idx;
    logic        r_out_last, n_out_last;
    logic        r_out_err, n_out_err;

    logic        out_free, in_ready, in_fire, ovf, absorb, refuse, finish, restart;
    logic [5:0]  pos;
    logic [31:0] pad_word;
    t_sched_ctl  sched_ctl;
    t_round_ctl  round_ctl;
    logic [31:0] w0, rd_data, hword, hsum;
    logic        rd_en, wr_en;
    logic [2:0]  rd_addr, wr_addr;

    assign out_free = !r_out_valid || o_out_ch.ready;
    assign in_fire  = i_in_ch.valid && in_ready;
    assign ovf      = &r_cnt;
    assign absorb   = in_fire && !i_in_ch.mode && !ovf;
    assign refuse   = in_fire && !i_in_ch.mode && ovf;
    assign finish   = in_fire && i_in_ch.mode;
    assign pos      = r_cnt[5:0];
    assign hword    = r_rd_iv ? f_iv(r_rd_idx) : rd_data;
    assign restart  = (r_state == S_EMIT_WR) && out_free && (r_idx == LAST_HWORD);

    always_comb begin
        case (pos[1:0])
            2'd0:    pad_word = {PAD_MARK, 24'h0};
            2'd1:    pad_word = {r_word[7:0], PAD_MARK, 16'h0};
            2'd2:    pad_word = {r_word[15:0], PAD_MARK, 8'h0};
            default: pad_word = {r_word[23:0], PAD_MARK};
        endcase
    end

    // next state and register updates
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_cnt       = r_cnt;
        n_word      = r_word;
        n_wcnt      = r_wcnt;
        n_round     = r_round;
        n_idx       = r_idx;
        n_hvalid    = r_hvalid;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out_word  = r_out_word;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_err   = r_out_err;
        if (wr_en) begin
            n_hvalid[wr_addr] = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (absorb) begin
                    n_cnt  = 61'(r_cnt + 61'd1);
                    n_word = {r_word[15:0], i_in_ch.message_byte};
                    if (pos == 6'(BLOCK_BYTES - 1)) begin
                        n_state = S_ROUND;
                        n_round = '0;
                        n_ret   = S_IDLE;
                    end
                end else if (refuse) begin
                    n_out_valid = 1'b1;
                    n_out_word  = '0;
                    n_out_idx   = '0;
                    n_out_last  = 1'b0;
                    n_out_err   = 1'b1;
                end else if (finish) begin
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                n_wcnt  = {1'b0, pos[5:2]} + 5'd1;
                n_state = S_ZERO;
            end
            S_ZERO: begin
                if (r_wcnt == LEN_WORD) begin
                    n_state = S_LEN_HI;
                end else if (r_wcnt == FULL_WORDS) begin
                    n_wcnt  = '0;
                    n_state = S_ROUND;
                    n_round = '0;
                    n_ret   = S_ZERO;
                end else begin
                    n_wcnt = r_wcnt + 5'd1;
                end
            end
            S_LEN_HI: begin
                n_state = S_LEN_LO;
            end
            S_LEN_LO: begin
                n_state = S_ROUND;
                n_round = '0;
                n_ret   = S_EMIT_RD;
            end
            S_ROUND: begin
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FIN;
                    n_idx   = '0;
                end
            end
            S_FIN: begin
                n_idx = r_idx + 3'd1;
                if (r_idx == FIN_DONE) begin
                    n_idx   = '0;
                    n_state = r_ret;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = hword;
                    n_out_idx   = r_idx;
                    n_out_last  = (r_idx == LAST_HWORD);
                    n_out_err   = 1'b0;
                    if (r_idx == LAST_HWORD) begin
                        n_idx    = '0;
                        n_cnt    = '0;
                        n_hvalid = '0;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        in_ready         = 1'b0;
        sched_ctl        = '0;
        round_ctl        = '0;
        round_ctl.round  = r_round;
        round_ctl.init   = restart;
        rd_en            = 1'b0;
        rd_addr          = r_idx;
        wr_en            = 1'b0;
        wr_addr          = r_idx - 3'd1;
        case (r_state)
            S_IDLE: begin
                in_ready = out_free;
                if (absorb && (pos[1:0] == 2'd3)) begin
                    sched_ctl.push = 1'b1;
                    sched_ctl.word = {r_word, i_in_ch.message_byte};
                end
            end
            S_PAD: begin
                sched_ctl.push = 1'b1;
                sched_ctl.word = pad_word;
            end
            S_ZERO: begin
                sched_ctl.push = (r_wcnt != LEN_WORD) && (r_wcnt != FULL_WORDS);
            end
            S_LEN_HI: begin
                sched_ctl.push = 1'b1;
                sched_ctl.word = r_cnt[60:29];
            end
            S_LEN_LO: begin
                sched_ctl.push = 1'b1;
                sched_ctl.word = {r_cnt[28:0], 3'b000};
            end
            S_ROUND: begin
                sched_ctl.push   = 1'b1;
                sched_ctl.expand = 1'b1;
                round_ctl.step   = 1'b1;
            end
            S_FIN: begin
                rd_en         = (r_idx != FIN_DONE);
                wr_en         = (r_idx != 3'd0);
                round_ctl.rot = (r_idx != 3'd0);
            end
            S_EMIT_RD: begin
                rd_en = 1'b1;
            end
            S_EMIT_WR: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_cnt       <= '0;
            r_wcnt      <= '0;
            r_round     <= '0;
            r_idx       <= '0;
            r_hvalid    <= '0;
            r_rd_iv     <= 1'b1;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_cnt       <= n_cnt;
            r_wcnt      <= n_wcnt;
            r_round     <= n_round;
            r_idx       <= n_idx;
            r_hvalid    <= n_hvalid;
            r_out_valid <= n_out_valid;
            if (rd_en) begin
                r_rd_iv  <= !r_hvalid[rd_addr];
                r_rd_idx <= rd_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_out_word <= n_out_word;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    sha1he_ram #(
        .WIDTH(32),
        .DEPTH(HASH_WORDS)
    ) u_hash_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (hsum),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sha1he_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (sched_ctl),
        .o_w0  (w0)
    );

    sha1he_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (round_ctl),
        .i_w     (w0),
        .i_hword (hword),
        .o_sum   (hsum)
    );

    assign i_in_ch.ready           = in_ready;
    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.digest_word    = r_out_word;
    assign o_out_ch.word_index     = r_out_idx;
    assign o_out_ch.last_word      = r_out_last;
    assign o_out_ch.overflow_error = r_out_err;

    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND && n_state == S_ROUND) |=> (r_round == 7'd0))
        else $error("compression started mid-count");

    a_wcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ZERO) |-> (r_wcnt <= FULL_WORDS))
        else $error("schedule fill count out of range");

    a_ram_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("hash memory read and write hit one entry");

    a_last_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_idx == LAST_HWORD && !r_out_err))
        else $error("bad final digest beat");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (r_hvalid == 5'd0 && r_cnt == 61'd0))
        else $error("hash state not restarted after digest");
endmodule
